/* src/lacs_pkg.sv */
// Shared constants, codes and types of the line aligned chunk splitter.
package lacs_pkg;

  localparam int POS_BITS    = 48;
  localparam int MAX_CHUNKS  = 64;
  localparam int IDX_BITS    = $clog2(MAX_CHUNKS);
  localparam int CNT_BITS    = 7;
  localparam int FRONT_DEPTH = 4;
  localparam int ADDR_BITS   = 6;
  localparam int DATA_BITS   = 64;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Register indexes, taken from paddr[5:3]
  localparam logic [2:0] REG_CHUNK_COUNT    = 3'd0;
  localparam logic [2:0] REG_TOTAL_SIZE     = 3'd1;
  localparam logic [2:0] REG_INITIAL_OFFSET = 3'd2;
  localparam logic [2:0] REG_SIZE_FLOOR     = 3'd3;
  localparam logic [2:0] REG_ONLY_CRLF_MODE = 3'd4;

  // One classified input byte
  typedef struct packed {
    logic is_cr;
    logic is_lf;
  } byte_t;

  // One chunk record; positions are relative, offset is added at the ports
  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] last_pos;
    logic                status;
    logic                is_last;
  } rec_t;

  // Configuration register values
  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic [POS_BITS-1:0] total;
    logic [POS_BITS-1:0] offset;
    logic [POS_BITS-1:0] size_floor;
    logic                crlf;
  } cfg_t;

endpackage

/* src/lacs_front.sv */
// Front end: input byte queue that classifies CR and LF on entry.
module lacs_front import lacs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output byte_t      head_o
);

  localparam int PTR_BITS = $clog2(FRONT_DEPTH);

  byte_t               mem_q [FRONT_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_BITS:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;
  byte_t               item;

  assign full_o  = (cnt_q == (PTR_BITS+1)'(FRONT_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Classify the byte as it enters
  always_comb begin
    item.is_cr = (data_i == CH_CR);
    item.is_lf = (data_i == CH_LF);
  end

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PTR_BITS+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - (PTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the transfer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

/* src/lacs_div.sv */
// Restoring divider: total size over chunk count, one quotient bit a cycle.
module lacs_div import lacs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [POS_BITS-1:0] dividend_i,
  input  logic [CNT_BITS-1:0] divisor_i,
  output logic                done_o,
  output logic [POS_BITS-1:0] quot_o
);

  localparam int STEP_BITS = $clog2(POS_BITS);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic [CNT_BITS-1:0]  rem_q, rem_d;
  logic [CNT_BITS-1:0]  dvs_q, dvs_d;
  logic [POS_BITS-1:0]  quot_q, quot_d;
  logic [CNT_BITS:0]    trial;
  logic                 fits;

  assign done_o = done_q;
  assign quot_o = quot_q;

  assign trial = {rem_q, quot_q[POS_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  // Shift in one dividend bit, subtract where the divisor fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quot_d = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? CNT_BITS'(trial - {1'b0, dvs_q}) : trial[CNT_BITS-1:0];
      quot_d = {quot_q[POS_BITS-2:0], fits};
      step_d = step_q + STEP_BITS'(1);
      if (step_q == STEP_BITS'(POS_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

endmodule

/* src/lacs_rec_q.sv */
// Two-entry record queue between the back end and the result ports.
module lacs_rec_q import lacs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t head_o
);

  rec_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

/* src/lacs_back.sv */
// Back end: newline search, chunk bookkeeping and record sequencing.
module lacs_back import lacs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                byte_valid_i,
  input  byte_t               byte_i,
  output logic                byte_pop_o,
  input  logic                rec_full_i,
  output logic                rec_push_o,
  output rec_t                rec_o,
  output logic [POS_BITS-1:0] run_offset_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV     = 3'd1;
  localparam logic [2:0] ST_RUN     = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_FINISH  = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_SCAN = 2'd1;
  localparam logic [1:0] PH_SEEN = 2'd2;

  logic [2:0]          state_q, state_d;
  logic [1:0]          phase_q, phase_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic [POS_BITS-1:0] total_q, total_d;
  logic [POS_BITS-1:0] offset_q, offset_d;
  logic                crlf_q, crlf_d;
  logic [POS_BITS-1:0] base_q, base_d;
  logic [POS_BITS-1:0] nom_q, nom_d;
  logic [CNT_BITS-1:0] idx_q, idx_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] r_q, r_d;
  logic [POS_BITS-1:0] p_q, p_d;
  logic                fin_q, fin_d;

  logic                div_start;
  logic                div_done;
  logic [POS_BITS-1:0] div_quot;

  logic                cfg_bad;
  logic [1:0]          ph_cur, ph_nxt;
  logic                resolve;
  logic [POS_BITS-1:0] r_run;
  logic [POS_BITS-1:0] pos_inc;
  logic                at_end;
  logic [CNT_BITS-1:0] idx_inc;
  logic [POS_BITS-1:0] nom_inc;
  logic                more_chunks;

  // Record with an inclusive end; an inverted chunk ends at its start
  function automatic rec_t make_rec(input logic [CNT_BITS-1:0] idx,
                                    input logic [POS_BITS-1:0] s,
                                    input logic [POS_BITS-1:0] e,
                                    input logic                is_last);
    rec_t rec;
    rec.idx      = idx[IDX_BITS-1:0];
    rec.start    = s;
    rec.last_pos = (s >= e) ? s : e - POS_BITS'(1);
    rec.status   = 1'b0;
    rec.is_last  = is_last;
    return rec;
  endfunction

  // Next nominal boundary also lies before the split point found
  function automatic logic loop_more(input logic [CNT_BITS-1:0] idx_n,
                                     input logic [POS_BITS-1:0] nom_n,
                                     input logic [POS_BITS-1:0] r,
                                     input logic [CNT_BITS-1:0] cnt,
                                     input logic                crlf);
    return ((idx_n + CNT_BITS'(1)) < cnt) &&
           (({1'b0, nom_n} + {{POS_BITS{1'b0}}, crlf}) < {1'b0, r});
  endfunction

  // Search phase once the skipped boundaries are used up
  function automatic logic [1:0] exit_phase(input logic [CNT_BITS-1:0] idx_n,
                                            input logic [POS_BITS-1:0] nom_n,
                                            input logic [POS_BITS-1:0] p,
                                            input logic [CNT_BITS-1:0] cnt);
    logic [1:0] ph;
    ph = PH_WAIT;
    if (((idx_n + CNT_BITS'(1)) < cnt) && (nom_n <= p)) begin
      ph = PH_SCAN;
    end
    return ph;
  endfunction

  lacs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg_i.total),
    .divisor_i  (cfg_i.count),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign run_offset_o = offset_q;

  assign cfg_bad = (cfg_i.count == '0) || (cfg_i.count > CNT_BITS'(MAX_CHUNKS)) ||
                   (cfg_i.total == '0) || (cfg_i.total < cfg_i.size_floor);

  assign pos_inc     = pos_q + POS_BITS'(1);
  assign at_end      = (pos_inc >= total_q);
  assign idx_inc     = idx_q + CNT_BITS'(1);
  assign nom_inc     = nom_q + base_q;
  assign more_chunks = (idx_inc < count_q);

  // Classify the head byte against the search phase
  always_comb begin
    ph_cur = phase_q;
    if ((phase_q == PH_WAIT) && more_chunks && (pos_q >= nom_q)) begin
      ph_cur = PH_SCAN;
    end
    ph_nxt  = ph_cur;
    resolve = 1'b0;
    r_run   = pos_q;
    case (ph_cur)
      PH_SCAN: begin
        if (crlf_q ? byte_i.is_cr : (byte_i.is_cr || byte_i.is_lf)) begin
          ph_nxt = PH_SEEN;
        end
      end
      PH_SEEN: begin
        if (!crlf_q) begin
          if (!(byte_i.is_cr || byte_i.is_lf)) begin
            resolve = 1'b1;
          end
        end else if (byte_i.is_lf) begin
          resolve = 1'b1;
          r_run   = pos_inc;
        end else if (!byte_i.is_cr) begin
          ph_nxt = PH_SCAN;
        end
      end
      default: begin
        ph_nxt = ph_cur;
      end
    endcase
  end

  // Sequence the run: setup, per-byte search, skipped chunks, tail records
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    count_d    = count_q;
    total_d    = total_q;
    offset_d   = offset_q;
    crlf_d     = crlf_q;
    base_d     = base_q;
    nom_d      = nom_q;
    idx_d      = idx_q;
    start_d    = start_q;
    pos_d      = pos_q;
    r_d        = r_q;
    p_d        = p_q;
    fin_d      = fin_q;
    div_start  = 1'b0;
    byte_pop_o = 1'b0;
    rec_push_o = 1'b0;
    rec_o      = make_rec(idx_q, start_q, r_q, 1'b0);

    case (state_q)
      ST_IDLE: begin
        if (byte_valid_i) begin
          count_d  = cfg_i.count;
          total_d  = cfg_i.total;
          offset_d = cfg_i.offset;
          crlf_d   = cfg_i.crlf;
          idx_d    = '0;
          start_d  = '0;
          pos_d    = '0;
          phase_d  = PH_WAIT;
          if (cfg_bad) begin
            if (!rec_full_i) begin
              rec_push_o     = 1'b1;
              rec_o.idx      = '0;
              rec_o.start    = '0;
              rec_o.last_pos = '0;
              rec_o.status   = 1'b1;
              rec_o.is_last  = 1'b1;
              byte_pop_o     = 1'b1;
              state_d        = ST_DONE;
            end
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          base_d  = div_quot;
          nom_d   = div_quot;
          state_d = ST_RUN;
        end
      end

      ST_RUN: begin
        if (byte_valid_i && (!resolve || !rec_full_i)) begin
          byte_pop_o = 1'b1;
          pos_d      = pos_inc;
          phase_d    = ph_nxt;
          if (resolve) begin
            rec_push_o = 1'b1;
            rec_o      = make_rec(idx_q, start_q, r_run, 1'b0);
            start_d    = r_run;
            idx_d      = idx_inc;
            nom_d      = nom_inc;
            r_d        = r_run;
            p_d        = pos_q;
            fin_d      = at_end;
            if (loop_more(idx_inc, nom_inc, r_run, count_q, crlf_q)) begin
              state_d = ST_RESOLVE;
            end else begin
              phase_d = exit_phase(idx_inc, nom_inc, pos_q, count_q);
              state_d = at_end ? ST_FINISH : ST_RUN;
            end
          end else if (at_end) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_RESOLVE: begin
        if (!rec_full_i) begin
          rec_push_o = 1'b1;
          rec_o      = make_rec(idx_q, start_q, r_q, 1'b0);
          start_d    = r_q;
          idx_d      = idx_inc;
          nom_d      = nom_inc;
          if (!loop_more(idx_inc, nom_inc, r_q, count_q, crlf_q)) begin
            phase_d = exit_phase(idx_inc, nom_inc, p_q, count_q);
            state_d = fin_q ? ST_FINISH : ST_RUN;
          end
        end
      end

      ST_FINISH: begin
        if (!rec_full_i) begin
          rec_push_o = 1'b1;
          if (more_chunks) begin
            rec_o   = make_rec(idx_q, start_q, nom_q, 1'b0);
            start_d = nom_q;
            idx_d   = idx_inc;
            nom_d   = nom_inc;
          end else begin
            rec_o   = make_rec(idx_q, start_q, total_q, 1'b1);
            idx_d   = idx_inc;
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // Drop every further byte
        byte_pop_o = byte_valid_i;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_WAIT;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    total_q  <= total_d;
    offset_q <= offset_d;
    crlf_q   <= crlf_d;
    base_q   <= base_d;
    nom_q    <= nom_d;
    idx_q    <= idx_d;
    start_q  <= start_d;
    pos_q    <= pos_d;
    r_q      <= r_d;
    p_q      <= p_d;
    fin_q    <= fin_d;
  end

endmodule

/* src/line_aligned_chunk_splitter.sv */
// Top level: configuration registers, front and back ends, result ports.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  bytes in | push / full             | data_byte_i
//  records  | empty / pop             | chunk_index_o chunk_start_o chunk_end_o
//           |                         | split_status_o last_record_o
//  config   | psel penable pwrite     | paddr pwdata prdata, pready tied high
//
// A transfer can enter the byte queue every cycle while full is low.
// The first byte of a run waits at the head of the byte queue while the back end
// starts the chunk size divider, the divider forms its 48 quotient bits and the
// quotient is taken; then the queued bytes drain at one a cycle while the
// record queue has room. A split that skips boundaries pushes one extra record
// per skipped boundary; after the last byte, each remaining record is pushed.
// Reset clears the queues and the sequencer; a full record queue stalls the
// back end, which backs up the byte queue and raises full.
module line_aligned_chunk_splitter import lacs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [IDX_BITS-1:0]  chunk_index_o,
  output logic [POS_BITS-1:0]  chunk_start_o,
  output logic [POS_BITS-1:0]  chunk_end_o,
  output logic                 split_status_o,
  output logic                 last_record_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t                cfg_q;
  logic                cfg_wr;
  logic [2:0]          reg_idx;

  logic                byte_valid;
  byte_t               byte_head;
  logic                byte_pop;
  logic                rec_full;
  logic                rec_push;
  rec_t                rec_in;
  rec_t                rec_head;
  logic [POS_BITS-1:0] run_offset;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count      <= CNT_BITS'(1);
      cfg_q.total      <= POS_BITS'(1);
      cfg_q.offset     <= '0;
      cfg_q.size_floor <= '0;
      cfg_q.crlf       <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CHUNK_COUNT:    cfg_q.count      <= pwdata[CNT_BITS-1:0];
        REG_TOTAL_SIZE:     cfg_q.total      <= pwdata[POS_BITS-1:0];
        REG_INITIAL_OFFSET: cfg_q.offset     <= pwdata[POS_BITS-1:0];
        REG_SIZE_FLOOR:     cfg_q.size_floor <= pwdata[POS_BITS-1:0];
        REG_ONLY_CRLF_MODE: cfg_q.crlf       <= pwdata[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_CHUNK_COUNT:    prdata = DATA_BITS'(cfg_q.count);
      REG_TOTAL_SIZE:     prdata = DATA_BITS'(cfg_q.total);
      REG_INITIAL_OFFSET: prdata = DATA_BITS'(cfg_q.offset);
      REG_SIZE_FLOOR:     prdata = DATA_BITS'(cfg_q.size_floor);
      REG_ONLY_CRLF_MODE: prdata = DATA_BITS'(cfg_q.crlf);
      default:            prdata = '0;
    endcase
  end

  lacs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (data_byte_i),
    .full_o  (full),
    .pop_i   (byte_pop),
    .valid_o (byte_valid),
    .head_o  (byte_head)
  );

  lacs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_head),
    .byte_pop_o   (byte_pop),
    .rec_full_i   (rec_full),
    .rec_push_o   (rec_push),
    .rec_o        (rec_in),
    .run_offset_o (run_offset)
  );

  lacs_rec_q u_rec_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (rec_full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (rec_head)
  );

  // Make positions absolute; the error record reports zero
  assign chunk_index_o  = rec_head.idx;
  assign chunk_start_o  = rec_head.status ? '0 : POS_BITS'(rec_head.start + run_offset);
  assign chunk_end_o    = rec_head.status ? '0 : POS_BITS'(rec_head.last_pos + run_offset);
  assign split_status_o = rec_head.status;
  assign last_record_o  = rec_head.is_last;

  // The back end never pushes a record into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) rec_push |-> !rec_full)
    else $error("record pushed into full queue");

  // The back end only consumes bytes that are queued
  assert property (@(posedge clk_i) disable iff (!rst_ni) byte_pop |-> byte_valid)
    else $error("byte popped from empty queue");

  // An error record is the only and final record, for chunk zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && split_status_o) |-> (last_record_o && chunk_index_o == '0))
    else $error("error record not final");

  // A pushed error record leaves the back end draining bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (rec_push && rec_in.status) |=> !rec_push)
    else $error("record after error record");

endmodule
